// ----- sv/hmlf_pkg.sv -----
// shared types, constants and character helpers for the http length framer
`timescale 1ns / 1ps
package hmlf_pkg;

	localparam int LEN_BITS = 32;
	localparam int OUT_BITS = 32;
	localparam int KEY_LEN = 16;
	localparam int KEY_IDX_BITS = $clog2(KEY_LEN);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PREFIX,
		PH_HEADER,
		PH_DONE,
		PH_BAD
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_GET,
		KIND_POST,
		KIND_RESP
	} kind_t;

	typedef enum logic [1:0] {
		VS_PRE,
		VS_DIGITS,
		VS_END
	} value_stage_t;

	typedef enum logic [1:0] {
		ST_INCOMPLETE,
		ST_COMPLETE,
		ST_NOT_HTTP
	} status_t;

	// verdict request handed from the parser to the result stage
	typedef struct packed {
		logic bad;
		logic done;
		logic use_len;
		logic [LEN_BITS-1:0] body_len;
		logic [LEN_BITS-1:0] byte_count;
		logic [LEN_BITS-1:0] header_len;
	} verdict_req_t;

	function automatic logic [7:0] prefix_char(input kind_t kind, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case (kind)
			KIND_GET: begin
				case (pos)
					3'd0: ch = "G";
					3'd1: ch = "E";
					3'd2: ch = "T";
					3'd3: ch = " ";
					default: ch = 8'h00;
				endcase
			end
			KIND_POST: begin
				case (pos)
					3'd0: ch = "P";
					3'd1: ch = "O";
					3'd2: ch = "S";
					3'd3: ch = "T";
					3'd4: ch = " ";
					default: ch = 8'h00;
				endcase
			end
			KIND_RESP: begin
				case (pos)
					3'd0: ch = "H";
					3'd1: ch = "T";
					3'd2: ch = "T";
					3'd3: ch = "P";
					3'd4: ch = "/";
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [2:0] prefix_len(input kind_t kind);
		return (kind == KIND_GET) ? 3'd4 : 3'd5;
	endfunction

	function automatic logic [7:0] key_char(input logic [KEY_IDX_BITS-1:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0: ch = "C";
			4'd1: ch = "o";
			4'd2: ch = "n";
			4'd3: ch = "t";
			4'd4: ch = "e";
			4'd5: ch = "n";
			4'd6: ch = "t";
			4'd7: ch = "-";
			4'd8: ch = "L";
			4'd9: ch = "e";
			4'd10: ch = "n";
			4'd11: ch = "g";
			4'd12: ch = "t";
			4'd13: ch = "h";
			4'd14: ch = ":";
			4'd15: ch = " ";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
			(c == 8'h0C) || (c == 8'h0D);
	endfunction

	// saturate a length onto the output width
	function automatic logic [OUT_BITS-1:0] clip_out(input logic [LEN_BITS-1:0] v);
		logic [LEN_BITS+OUT_BITS-1:0] w;
		logic [LEN_BITS+OUT_BITS-1:0] lim;
		w = {{OUT_BITS{1'b0}}, v};
		lim = {{LEN_BITS{1'b0}}, {OUT_BITS{1'b1}}};
		return (w > lim) ? {OUT_BITS{1'b1}} : w[OUT_BITS-1:0];
	endfunction

endpackage

// ----- sv/hmlf_front.sv -----
// byte parser: prefix check, header end search, content-length key and value
`timescale 1ns / 1ps
module hmlf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            data_byte,
	input  logic                  start_of_message,
	input  logic                  end_of_data,
	output logic                  req_valid,
	output hmlf_pkg::verdict_req_t req
);

	localparam int L = hmlf_pkg::LEN_BITS;
	localparam int KB = hmlf_pkg::KEY_IDX_BITS;

	hmlf_pkg::phase_t       phase_q, phase_d;
	hmlf_pkg::kind_t        kind_q, kind_d;
	hmlf_pkg::value_stage_t vstage_q, vstage_d;
	logic [2:0]    ppos_q, ppos_d;
	logic [1:0]    blank_q, blank_d;
	logic [KB-1:0] key_q, key_d;
	logic          found_q, found_d;
	logic          digits_q, digits_d;
	logic [L-1:0]  acc_q, acc_d;
	logic [L-1:0]  count_q, count_d;
	logic [L-1:0]  hdr_q, hdr_d;

	logic          prev_cr;
	logic          is_digit;
	logic [L+3:0]  acc_x10;
	logic [7:0]    c;

	assign c = data_byte;
	assign is_digit = (c inside {[hmlf_pkg::CH_ZERO:hmlf_pkg::CH_NINE]});
	// acc * 10 + digit, with headroom to spot overflow
	assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
		{{(L){1'b0}}, c[3:0]};

	always_comb begin
		phase_d = phase_q;
		kind_d = kind_q;
		vstage_d = vstage_q;
		ppos_d = ppos_q;
		blank_d = blank_q;
		key_d = key_q;
		found_d = found_q;
		digits_d = digits_q;
		acc_d = acc_q;
		count_d = count_q;
		hdr_d = hdr_q;
		prev_cr = 1'b0;

		if (start_of_message) begin
			phase_d = hmlf_pkg::PH_PREFIX;
			kind_d = hmlf_pkg::KIND_NONE;
			vstage_d = hmlf_pkg::VS_PRE;
			ppos_d = '0;
			blank_d = '0;
			key_d = '0;
			found_d = 1'b0;
			digits_d = 1'b0;
			acc_d = '0;
			count_d = '0;
			hdr_d = '0;
		end

		if (phase_d != hmlf_pkg::PH_IDLE && phase_d != hmlf_pkg::PH_BAD) begin
			if (count_d != {L{1'b1}})
				count_d = count_d + 1'b1;
			case (phase_d)
				hmlf_pkg::PH_PREFIX: begin
					if (ppos_d == 3'd0) begin
						if (c == "G")
							kind_d = hmlf_pkg::KIND_GET;
						else if (c == "P")
							kind_d = hmlf_pkg::KIND_POST;
						else if (c == "H")
							kind_d = hmlf_pkg::KIND_RESP;
						else
							kind_d = hmlf_pkg::KIND_NONE;
					end
					if (kind_d == hmlf_pkg::KIND_NONE ||
						c != hmlf_pkg::prefix_char(kind_d, ppos_d)) begin
						phase_d = hmlf_pkg::PH_BAD;
					end else begin
						ppos_d = ppos_d + 3'd1;
						if (ppos_d == hmlf_pkg::prefix_len(kind_d))
							phase_d = hmlf_pkg::PH_HEADER;
					end
				end
				hmlf_pkg::PH_HEADER: begin
					prev_cr = (blank_d == 2'd1) || (blank_d == 2'd3);
					if (digits_d) begin
						if (c == hmlf_pkg::CH_LF && prev_cr) begin
							found_d = 1'b1;
							digits_d = 1'b0;
						end else begin
							case (vstage_d)
								hmlf_pkg::VS_PRE: begin
									if (hmlf_pkg::is_space(c)) begin
										vstage_d = hmlf_pkg::VS_PRE;
									end else if (c == hmlf_pkg::CH_PLUS) begin
										vstage_d = hmlf_pkg::VS_DIGITS;
									end else if (c == hmlf_pkg::CH_MINUS) begin
										acc_d = '0;
										vstage_d = hmlf_pkg::VS_END;
									end else if (is_digit) begin
										acc_d = {{(L-4){1'b0}}, c[3:0]};
										vstage_d = hmlf_pkg::VS_DIGITS;
									end else begin
										vstage_d = hmlf_pkg::VS_END;
									end
								end
								hmlf_pkg::VS_DIGITS: begin
									if (is_digit) begin
										if (|acc_x10[L+3:L])
											acc_d = {L{1'b1}};
										else
											acc_d = acc_x10[L-1:0];
									end else begin
										vstage_d = hmlf_pkg::VS_END;
									end
								end
								default: vstage_d = hmlf_pkg::VS_END;
							endcase
						end
					end else if (!found_d) begin
						if (c == hmlf_pkg::key_char(key_d)) begin
							if (key_d == KB'(hmlf_pkg::KEY_LEN - 1)) begin
								key_d = '0;
								digits_d = 1'b1;
								acc_d = '0;
								vstage_d = hmlf_pkg::VS_PRE;
							end else begin
								key_d = key_d + 1'b1;
							end
						end else begin
							key_d = (c == "C") ? KB'(1) : KB'(0);
						end
					end

					// blank line tracker, runs on every header byte
					if (blank_d == 2'd3 && c == hmlf_pkg::CH_LF) begin
						blank_d = 2'd0;
						hdr_d = count_d;
						phase_d = hmlf_pkg::PH_DONE;
					end else if ((blank_d == 2'd0 || blank_d == 2'd2) &&
						c == hmlf_pkg::CH_CR) begin
						blank_d = blank_d + 2'd1;
					end else if (blank_d == 2'd1 && c == hmlf_pkg::CH_LF) begin
						blank_d = 2'd2;
					end else begin
						blank_d = (c == hmlf_pkg::CH_CR) ? 2'd1 : 2'd0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hmlf_pkg::PH_IDLE;
			kind_q <= hmlf_pkg::KIND_NONE;
			vstage_q <= hmlf_pkg::VS_PRE;
			ppos_q <= '0;
			blank_q <= '0;
			key_q <= '0;
			found_q <= 1'b0;
			digits_q <= 1'b0;
			acc_q <= '0;
			count_q <= '0;
			hdr_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			kind_q <= kind_d;
			vstage_q <= vstage_d;
			ppos_q <= ppos_d;
			blank_q <= blank_d;
			key_q <= key_d;
			found_q <= found_d;
			digits_q <= digits_d;
			acc_q <= acc_d;
			count_q <= count_d;
			hdr_q <= hdr_d;
		end
	end

	assign req_valid = take & end_of_data;
	assign req.bad = (phase_d == hmlf_pkg::PH_BAD);
	assign req.done = (phase_d == hmlf_pkg::PH_DONE);
	assign req.use_len = (kind_d != hmlf_pkg::KIND_GET) && found_d;
	assign req.body_len = acc_d;
	assign req.byte_count = count_d;
	assign req.header_len = hdr_d;

endmodule

// ----- sv/hmlf_queue.sv -----
// short request queue between the parser and the result stage
`timescale 1ns / 1ps
module hmlf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  hmlf_pkg::verdict_req_t wr_data,
	input  logic                  rd_en,
	output hmlf_pkg::verdict_req_t rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PB = hmlf_pkg::QPTR_BITS;

	hmlf_pkg::verdict_req_t mem_q [hmlf_pkg::QUEUE_DEPTH];
	logic [PB-1:0] wptr_q;
	logic [PB-1:0] rptr_q;
	logic [PB:0]   count_q;

	assign full = (count_q == (PB+1)'(hmlf_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en)
				wptr_q <= wptr_q + 1'b1;
			if (rd_en)
				rptr_q <= rptr_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/hmlf_back.sv -----
// result stage: total length, completeness check and the output register
`timescale 1ns / 1ps
module hmlf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_avail,
	input  hmlf_pkg::verdict_req_t req,
	output logic                  req_take,
	input  logic                  pop,
	output logic                  empty,
	output logic [1:0]            status,
	output logic [31:0]           message_length,
	output logic [31:0]           body_offset,
	output logic [31:0]           body_length
);

	localparam int L = hmlf_pkg::LEN_BITS;

	logic          valid_q;
	logic [1:0]    status_q;
	logic [31:0]   mlen_q;
	logic [31:0]   boff_q;
	logic [31:0]   blen_q;

	logic [L-1:0]  blen;
	logic [L:0]    sum;
	logic [L-1:0]  total;
	hmlf_pkg::status_t st;
	logic [L-1:0]  ml;
	logic [L-1:0]  bo;
	logic [L-1:0]  bl;

	// output register frees up when empty or being taken this cycle
	assign req_take = req_avail && (!valid_q || pop);

	assign blen = req.use_len ? req.body_len : '0;
	assign sum = {1'b0, req.header_len} + {1'b0, blen};
	assign total = sum[L] ? {L{1'b1}} : sum[L-1:0];

	always_comb begin
		st = hmlf_pkg::ST_INCOMPLETE;
		ml = '0;
		bo = '0;
		bl = '0;
		if (req.bad) begin
			st = hmlf_pkg::ST_NOT_HTTP;
		end else if (req.done) begin
			bo = req.use_len ? req.header_len : '0;
			bl = blen;
			if (req.byte_count >= total) begin
				st = hmlf_pkg::ST_COMPLETE;
				ml = total;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (req_take)
			valid_q <= 1'b1;
		else if (pop)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			status_q <= st;
			mlen_q <= hmlf_pkg::clip_out(ml);
			boff_q <= hmlf_pkg::clip_out(bo);
			blen_q <= hmlf_pkg::clip_out(bl);
		end
	end

	assign empty = !valid_q;
	assign status = status_q;
	assign message_length = mlen_q;
	assign body_offset = boff_q;
	assign body_length = blen_q;

endmodule

// ----- sv/http_message_length_framer_unit.sv -----
// a byte with end_of_data writes a verdict request into the queue, and the output register takes it when free
// throughput: one byte per cycle while the queue is not full, one verdict per cycle while the receiver pops
// a four-entry request queue and the output register let both sides stall on their own
// reset: arst_n clears parser state, queue and the output valid flag; the block waits for a message start
// bytes before the first start_of_message are taken and ignored
`timescale 1ns / 1ps
module http_message_length_framer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        start_of_message,
	input  logic        end_of_data,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [31:0] message_length,
	output logic [31:0] body_offset,
	output logic [31:0] body_length
);

	logic                   take;
	logic                   req_valid;
	hmlf_pkg::verdict_req_t req_in;
	hmlf_pkg::verdict_req_t req_out;
	logic                   q_full;
	logic                   q_empty;
	logic                   req_take;

	assign full = q_full;
	assign take = push && !q_full;

	hmlf_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.data_byte        (data_byte),
		.start_of_message (start_of_message),
		.end_of_data      (end_of_data),
		.req_valid        (req_valid),
		.req              (req_in)
	);

	hmlf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (req_valid),
		.wr_data (req_in),
		.rd_en   (req_take),
		.rd_data (req_out),
		.full    (q_full),
		.empty   (q_empty)
	);

	hmlf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_avail      (!q_empty),
		.req            (req_out),
		.req_take       (req_take),
		.pop            (pop),
		.empty          (empty),
		.status         (status),
		.message_length (message_length),
		.body_offset    (body_offset),
		.body_length    (body_length)
	);

`ifndef ASSERT_OFF
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == hmlf_pkg::ST_INCOMPLETE || status == hmlf_pkg::ST_COMPLETE ||
			status == hmlf_pkg::ST_NOT_HTTP))
		else $error("result carries an undefined status code");

	a_len_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != hmlf_pkg::ST_COMPLETE) |-> message_length == '0)
		else $error("message length reported without a complete verdict");

	a_not_http_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == hmlf_pkg::ST_NOT_HTTP) |->
			(body_offset == '0 && body_length == '0))
		else $error("not-http verdict carries body fields");

	a_body_needs_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && body_length != '0) |-> body_offset != '0)
		else $error("body length reported without a body offset");
`endif

endmodule

// ----- tb/sv/hmlf_verdict_checker.sv -----
// verdict predictor and comparator for the http message length framer testbench
`timescale 1ns / 1ps
module hmlf_verdict_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        start_of_message,
	input  logic        end_of_data,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  status,
	input  logic [31:0] message_length,
	input  logic [31:0] body_offset,
	input  logic [31:0] body_length,
	output int          failures,
	output int          outstanding,
	output int          verdicts_seen,
	output int          completes_seen
);

	localparam logic [31:0] LEN_MAX = '1;
	localparam logic [8*4-1:0] GET_TEXT = "GET ";
	localparam logic [8*5-1:0] POST_TEXT = "POST ";
	localparam logic [8*5-1:0] RESP_TEXT = "HTTP/";
	localparam logic [8*16-1:0] KEY_TEXT = "Content-Length: ";

	typedef struct packed {
		hmlf_pkg::status_t st;
		logic [31:0] total;
		logic [31:0] offset;
		logic [31:0] body;
	} verdict_t;

	verdict_t expected_verdicts[$];

	hmlf_pkg::phase_t       phase;
	hmlf_pkg::kind_t        kind;
	hmlf_pkg::value_stage_t vstage;
	int           prefix_pos;
	int           blank_match;
	int           key_match;
	logic         len_found;
	logic         in_value;
	logic [31:0]  len_acc;
	logic [31:0]  nbytes;
	logic [31:0]  hdr_len;

	task automatic clear_message();
		kind = hmlf_pkg::KIND_NONE;
		vstage = hmlf_pkg::VS_PRE;
		prefix_pos = 0;
		blank_match = 0;
		key_match = 0;
		len_found = 1'b0;
		in_value = 1'b0;
		len_acc = '0;
		nbytes = '0;
		hdr_len = '0;
	endtask

	// advance the parser by one byte and queue the verdict that an end of data asks for
	task automatic predict_verdict(input logic [7:0] c, input logic som, input logic eod);
		logic        prev_cr;
		logic        is_digit;
		logic        is_white;
		logic [7:0]  want_char;
		int          plen;
		logic [63:0] wide;
		logic [32:0] total_sum;
		logic [31:0] blen;
		verdict_t    v;

		is_digit = (c >= hmlf_pkg::CH_ZERO) && (c <= hmlf_pkg::CH_NINE);
		is_white = (c == 8'h20) || (c == 8'h09) || ((c >= 8'h0A) && (c <= 8'h0D));
		if (som) begin
			clear_message();
			phase = hmlf_pkg::PH_PREFIX;
		end
		if (phase != hmlf_pkg::PH_IDLE && phase != hmlf_pkg::PH_BAD) begin
			if (nbytes != LEN_MAX)
				nbytes = nbytes + 32'd1;
			if (phase == hmlf_pkg::PH_PREFIX) begin
				if (prefix_pos == 0) begin
					case (c)
						"G": kind = hmlf_pkg::KIND_GET;
						"P": kind = hmlf_pkg::KIND_POST;
						"H": kind = hmlf_pkg::KIND_RESP;
						default: phase = hmlf_pkg::PH_BAD;
					endcase
				end
				if (phase == hmlf_pkg::PH_PREFIX) begin
					plen = (kind == hmlf_pkg::KIND_GET) ? 4 : 5;
					if (prefix_pos >= plen) begin
						phase = hmlf_pkg::PH_BAD;
					end else begin
						case (kind)
							hmlf_pkg::KIND_GET: want_char = GET_TEXT[8*(3-prefix_pos) +: 8];
							hmlf_pkg::KIND_POST: want_char = POST_TEXT[8*(4-prefix_pos) +: 8];
							default: want_char = RESP_TEXT[8*(4-prefix_pos) +: 8];
						endcase
						if (c != want_char) begin
							phase = hmlf_pkg::PH_BAD;
						end else begin
							prefix_pos++;
							if (prefix_pos == plen)
								phase = hmlf_pkg::PH_HEADER;
						end
					end
				end
			end else if (phase == hmlf_pkg::PH_HEADER) begin
				prev_cr = (blank_match == 1) || (blank_match == 3);
				if (in_value) begin
					if (c == hmlf_pkg::CH_LF && prev_cr) begin
						len_found = 1'b1;
						in_value = 1'b0;
					end else if (vstage == hmlf_pkg::VS_PRE) begin
						if (c == hmlf_pkg::CH_PLUS) begin
							vstage = hmlf_pkg::VS_DIGITS;
						end else if (c == hmlf_pkg::CH_MINUS) begin
							len_acc = '0;
							vstage = hmlf_pkg::VS_END;
						end else if (is_digit) begin
							len_acc = {24'd0, 8'(c - hmlf_pkg::CH_ZERO)};
							vstage = hmlf_pkg::VS_DIGITS;
						end else if (!is_white) begin
							vstage = hmlf_pkg::VS_END;
						end
					end else if (vstage == hmlf_pkg::VS_DIGITS) begin
						if (is_digit) begin
							wide = {32'd0, len_acc};
							wide = wide * 64'd10 + {56'd0, 8'(c - hmlf_pkg::CH_ZERO)};
							len_acc = (wide > {32'd0, LEN_MAX}) ? LEN_MAX : wide[31:0];
						end else begin
							vstage = hmlf_pkg::VS_END;
						end
					end
				end else if (!len_found) begin
					if (key_match < hmlf_pkg::KEY_LEN && c == KEY_TEXT[8*(15-key_match) +: 8])
						key_match++;
					else
						key_match = (c == "C") ? 1 : 0;
					if (key_match >= hmlf_pkg::KEY_LEN) begin
						key_match = 0;
						in_value = 1'b1;
						len_acc = '0;
						vstage = hmlf_pkg::VS_PRE;
					end
				end

				// blank line tracker runs on every header byte, value or not
				if (blank_match == 3 && c == hmlf_pkg::CH_LF) begin
					blank_match = 0;
					hdr_len = nbytes;
					phase = hmlf_pkg::PH_DONE;
				end else if ((blank_match == 0 || blank_match == 2) && c == hmlf_pkg::CH_CR) begin
					blank_match++;
				end else if (blank_match == 1 && c == hmlf_pkg::CH_LF) begin
					blank_match = 2;
				end else begin
					blank_match = (c == hmlf_pkg::CH_CR) ? 1 : 0;
				end
			end
		end

		if (eod) begin
			v = '0;
			v.st = hmlf_pkg::ST_INCOMPLETE;
			if (phase == hmlf_pkg::PH_BAD) begin
				v.st = hmlf_pkg::ST_NOT_HTTP;
			end else if (phase == hmlf_pkg::PH_DONE) begin
				blen = '0;
				if (kind != hmlf_pkg::KIND_GET && len_found) begin
					blen = len_acc;
					v.offset = hdr_len;
					v.body = blen;
				end
				total_sum = {1'b0, hdr_len} + {1'b0, blen};
				if (total_sum[32])
					total_sum = {1'b0, LEN_MAX};
				if (nbytes >= total_sum[31:0]) begin
					v.st = hmlf_pkg::ST_COMPLETE;
					v.total = total_sum[31:0];
				end
			end
			expected_verdicts = {expected_verdicts, v};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		if (!arst_n) begin
			phase = hmlf_pkg::PH_IDLE;
			clear_message();
			expected_verdicts.delete();
			outstanding = 0;
			failures = 0;
			verdicts_seen = 0;
			completes_seen = 0;
		end else begin
			if (pop && !empty) begin
				verdicts_seen++;
				if (expected_verdicts.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected verdict: status %0d length %0d offset %0d body %0d",
							status, message_length, body_offset, body_length);
				end else begin
					want = expected_verdicts.pop_front();
					if (want.st == hmlf_pkg::ST_COMPLETE)
						completes_seen++;
					if (status !== want.st || message_length !== want.total ||
						body_offset !== want.offset || body_length !== want.body) begin
						failures++;
						if (failures <= 10)
							$display("verdict %0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								verdicts_seen, want.st, want.total, want.offset, want.body,
								status, message_length, body_offset, body_length);
					end
				end
			end
			if (push && !full)
				predict_verdict(data_byte, start_of_message, end_of_data);
			outstanding = expected_verdicts.size();
		end
	end

endmodule

// ----- tb/sv/http_message_length_framer_unit_test.sv -----
// stimulus, receiver and final verdict for the http message length framer
`timescale 1ns / 1ps
module http_message_length_framer_unit_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 120;
	localparam int RANDOM_BYTES = 230;
	localparam int IDLE_PCT = 21;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        start_of_message = 1'b0;
	logic        end_of_data = 1'b0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [1:0]  status;
	logic [31:0] message_length;
	logic [31:0] body_offset;
	logic [31:0] body_length;

	int failures;
	int outstanding;
	int verdicts_seen;
	int completes_seen;

	logic       idle_on = 1'b1;
	int         hold_asked = 0;
	int         holds_done = 0;
	int         hold_left = 0;
	int         cycles = 0;
	int         bytes_sent = 0;
	int         verdicts_asked = 0;
	int         messages_sent = 0;
	logic [7:0] frame[$];

	always #1 clk = ~clk;

	http_message_length_framer_unit u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.data_byte        (data_byte),
		.start_of_message (start_of_message),
		.end_of_data      (end_of_data),
		.empty            (empty),
		.pop              (pop),
		.status           (status),
		.message_length   (message_length),
		.body_offset      (body_offset),
		.body_length      (body_length)
	);

	hmlf_verdict_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.data_byte        (data_byte),
		.start_of_message (start_of_message),
		.end_of_data      (end_of_data),
		.empty            (empty),
		.pop              (pop),
		.status           (status),
		.message_length   (message_length),
		.body_offset      (body_offset),
		.body_length      (body_length),
		.failures         (failures),
		.outstanding      (outstanding),
		.verdicts_seen    (verdicts_seen),
		.completes_seen   (completes_seen)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[http_message_length_framer_unit] ERROR");
			$finish;
		end
	end

	// receiver: random pops, plus a long hold-off whenever the stimulus asks for one
	always @(negedge clk) begin
		if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_asked) begin
			pop <= 1'b0;
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end else begin
			pop <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	task automatic offer_byte(input logic [7:0] b, input logic is_first, input logic is_last);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		start_of_message <= is_first;
		end_of_data <= is_last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
		if (is_last)
			verdicts_asked++;
	endtask

	task automatic add_byte(input logic [7:0] b);
		frame = {frame, b};
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic send_frame(input logic with_start, input int eod_pct);
		for (int i = 0; i < frame.size(); i++)
			offer_byte(frame[i], with_start && i == 0,
				(i == frame.size() - 1) || ($urandom_range(0, 99) < eod_pct));
		frame.delete();
		if (with_start)
			messages_sent++;
	endtask

	// appends one random message: mostly well-formed with random content, some noise
	task automatic build_message();
		int    shape;
		int    n;
		int    value;
		int    place;
		string cut;

		shape = $urandom_range(0, 99);
		if (shape < 12) begin
			n = $urandom_range(1, 12);
			repeat (n) add_byte(8'($urandom_range(0, 255)));
		end else if (shape < 22) begin
			// prefix, possibly cut short, sometimes with one bit flipped
			case ($urandom_range(0, 2))
				0: cut = "GET ";
				1: cut = "POST ";
				default: cut = "HTTP/";
			endcase
			n = $urandom_range(1, cut.len());
			for (int i = 0; i < n; i++)
				add_byte(cut[i]);
			if ($urandom_range(0, 1))
				frame[frame.size()-1] = frame[frame.size()-1] ^ (8'd1 << $urandom_range(0, 7));
			if ($urandom_range(0, 1))
				add_text("/ x\r\n\r\n");
		end else begin
			case ($urandom_range(0, 2))
				0: add_text("GET /a HTTP/1.1\r\n");
				1: add_text("POST /b HTTP/1.1\r\n");
				default: add_text("HTTP/1.1 200 OK\r\n");
			endcase
			repeat ($urandom_range(0, 2)) begin
				case ($urandom_range(0, 3))
					0: add_text("Content-Type: t\r\n");
					1: add_text("CContent-Lengt: 7\r\n");
					2: add_text("X\r\rY\r\n");
					default: begin
						repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(8'h21, 8'h7E)));
						add_text("\r\n");
					end
				endcase
			end
			value = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 9) : $urandom_range(10, 40);
			place = $urandom_range(0, 9);
			if (place < 7) begin
				add_text("Content-Length: ");
				case ($urandom_range(0, 7))
					0: begin
						repeat ($urandom_range(1, 3))
							case ($urandom_range(0, 3))
								0: add_byte(8'h20);
								1: add_byte(8'h09);
								2: add_byte(8'h0B);
								default: add_byte(8'h0C);
							endcase
						add_text($sformatf("%0d", value));
					end
					1: add_text($sformatf("+%0d", value));
					2: add_text($sformatf("-%0d", value));
					3: add_text($sformatf("%0d%0d", $urandom_range(1000000, 9999999),
						$urandom_range(1000, 9999)));
					4: add_text($sformatf("%0dz9", value));
					5: ;
					default: add_text($sformatf("%0d", value));
				endcase
				add_text("\r\n");
			end
			add_text("\r\n");
			if (place == 7)
				add_text("Content-Length: 5\r\n");
			n = $urandom_range(0, 1) ? value : $urandom_range(0, 12);
			repeat (n) add_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// a byte before any message start is not parsed, but its end_of_data still asks for a verdict
		offer_byte(8'hFF, 1'b0, 1'b1);
		add_text("GE");
		send_frame(1'b1, 100);
		add_byte("X");
		add_byte(8'h00);
		send_frame(1'b1, 100);
		add_text("GET \r\n\r\n");
		send_frame(1'b1, 0);
		add_text("POST Content-Length: -5\r\n\r\n");
		send_frame(1'b1, 0);
		add_text("HTTP/Content-Length: \t+2\r\n\r\n");
		send_frame(1'b1, 0);
		add_text("ab");
		send_frame(1'b0, 100);
		add_text("GET Content-Length: 3\r\n\r\n");
		send_frame(1'b1, 0);
		add_text("POST Content-Length: 4294967299\r\n\r\n");
		send_frame(1'b1, 0);

		// receiver stalls while every byte asks for a verdict, so the block backs up
		idle_on <= 1'b0;
		hold_asked <= hold_asked + 1;
		do
			build_message();
		while (frame.size() < 16);
		send_frame(1'b1, 100);

		begin : random_part
			int base_bytes;
			base_bytes = bytes_sent;
			while (bytes_sent - base_bytes < RANDOM_BYTES) begin
				// a calm stretch with no idling on either side, then idling again
				idle_on <= !((bytes_sent - base_bytes) inside {[60:180]});
				build_message();
				send_frame($urandom_range(0, 9) != 0, 12);
			end
		end
		push <= 1'b0;
		idle_on <= 1'b1;

		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("sent %0d bytes in %0d messages with %0d verdict requests",
			bytes_sent, messages_sent, verdicts_asked);
		$display("checked %0d verdicts (%0d complete), including a full-queue stall",
			verdicts_seen, completes_seen);
		if (failures == 0 && outstanding == 0)
			$display("[http_message_length_framer_unit] OK");
		else
			$display("[http_message_length_framer_unit] ERROR");
		$finish;
	end

endmodule
